### hdl/fp16_matrix_multiply_core_defines.svh
// assertion macros shared by the checker of the fp16 matrix multiply core
// expects signals aclk and aresetn in the scope where a macro is used
`ifndef FP16_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define FP16_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define FMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define FMM_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fmm_pkg.sv
// shared types and constants of the fp16 matrix multiply core
// no dependencies
package fmm_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2
    } op_t;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FETCH = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_ALIGN = 9'b000001000,
        ST_ADD   = 9'b000010000,
        ST_LZC   = 9'b000100000,
        ST_SHIFT = 9'b001000000,
        ST_ROUND = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    // register indexes on the config port
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    // fixed-point sum width, lsb weight 2^-48
    localparam int SUM_W = 82;

    // binary16 constants
    localparam logic [15:0] QNAN16  = 16'h7E00;
    localparam logic [15:0] PINF16  = 16'h7C00;
    localparam logic [15:0] NINF16  = 16'hFC00;
    localparam logic [15:0] NZERO16 = 16'h8000;

    // stream data widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int M_USED_W  = 28;

endpackage

### hdl/fp16_matrix_multiply_core.sv
// fp16 matrix multiply core: A and B stores, fused multiply-add sequencer
// depends on fmm_pkg
//
// channel  | direction | payload
// s_*      | in        | operation, row_index, col_index, element_value
// m_*      | out       | product_value, product_row, product_col
// apb      | in/out    | rows_in_use @0x0, inner_in_use @0x4, cols_in_use @0x8
//
// each inner step reads both stores and runs six fma stages
// before the accumulator is written back for the next step
// synchronous active-low reset clears control and config registers; stores are not cleared
// a finished result waits in the output register while the next item is taken
module fp16_matrix_multiply_core #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [7:2] row_index, [13:8] col_index, [29:14] element_value
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] product_value, [21:16] product_row, [27:22] product_col
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LDEPTH = MAX_ROWS * MAX_INNER;
    localparam int RDEPTH = MAX_INNER * MAX_COLS;
    localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int KW     = $clog2(MAX_INNER + 1);
    localparam int SW     = fmm_pkg::SUM_W;

    // saturate a register to 1 .. maxv
    function automatic logic [8:0] sat_dim(input logic [6:0] v, input int maxv);
        logic [8:0] r;
        if (v == 7'd0) begin
            r = 9'd1;
        end else if (int'(v) > maxv) begin
            r = 9'(maxv);
        end else begin
            r = {2'b00, v};
        end
        return r;
    endfunction

    // config registers
    logic [6:0] rows_cfg_reg, inner_cfg_reg, cols_cfg_reg;
    logic       cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg  <= 7'd1;
            inner_cfg_reg <= 7'd1;
            cols_cfg_reg  <= 7'd1;
        end else if (cfg_we) begin
            case (paddr[3:2])
                fmm_pkg::REG_ROWS:  rows_cfg_reg  <= pwdata[6:0];
                fmm_pkg::REG_INNER: inner_cfg_reg <= pwdata[6:0];
                fmm_pkg::REG_COLS:  cols_cfg_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            fmm_pkg::REG_ROWS:  prdata = {25'd0, rows_cfg_reg};
            fmm_pkg::REG_INNER: prdata = {25'd0, inner_cfg_reg};
            fmm_pkg::REG_COLS:  prdata = {25'd0, cols_cfg_reg};
            default:            prdata = 32'd0;
        endcase
    end

    logic [8:0] rows_eff, inner_eff, cols_eff;
    assign rows_eff  = sat_dim(rows_cfg_reg, MAX_ROWS);
    assign inner_eff = sat_dim(inner_cfg_reg, MAX_INNER);
    assign cols_eff  = sat_dim(cols_cfg_reg, MAX_COLS);

    // input item fields
    logic [1:0]  in_op;
    logic [5:0]  in_row, in_col;
    logic [15:0] in_value;
    logic        in_acc;
    assign in_op    = s_tdata[1:0];
    assign in_row   = s_tdata[7:2];
    assign in_col   = s_tdata[13:8];
    assign in_value = s_tdata[29:14];

    fmm_pkg::state_t state_reg, state_next;
    logic [5:0]    row_reg, col_reg;
    logic [KW-1:0] k_reg;
    logic [15:0]   acc_reg;

    assign s_tready = (state_reg == fmm_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // stores
    logic [15:0]    left_mem  [LDEPTH];
    logic [15:0]    right_mem [RDEPTH];
    logic [15:0]    left_rd_q, right_rd_q;
    logic           left_we, right_we;
    logic [LAW-1:0] left_waddr, left_raddr;
    logic [RAW-1:0] right_waddr, right_raddr;

    assign left_we  = in_acc && (in_op == fmm_pkg::OP_LOAD_LEFT)
                      && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_INNER);
    assign right_we = in_acc && (in_op == fmm_pkg::OP_LOAD_RIGHT)
                      && (int'(in_row) < MAX_INNER) && (int'(in_col) < MAX_COLS);
    assign left_waddr  = LAW'(int'(in_row) * MAX_INNER + int'(in_col));
    assign right_waddr = RAW'(int'(in_row) * MAX_COLS + int'(in_col));
    assign left_raddr  = LAW'(int'(row_reg) * MAX_INNER + int'(k_reg));
    assign right_raddr = RAW'(int'(k_reg) * MAX_COLS + int'(col_reg));

    always_ff @(posedge aclk) begin
        if (left_we) begin
            left_mem[left_waddr] <= in_value;
        end
        left_rd_q <= left_mem[left_raddr];
    end

    always_ff @(posedge aclk) begin
        if (right_we) begin
            right_mem[right_waddr] <= in_value;
        end
        right_rd_q <= right_mem[right_raddr];
    end

    // stage 1: operand decode, specials, significand product
    logic        x_nan, y_nan, a_nan, x_inf, y_inf, a_inf, x_zero, y_zero, a_zero;
    logic        c_ps, c_sa, c_sp;
    logic [15:0] c_spv;
    logic [10:0] c_mx, c_my, c_ma;
    logic [4:0]  c_qx, c_qy, c_qa;
    always_comb begin
        x_nan  = left_rd_q[14:0] > 15'h7C00;
        y_nan  = right_rd_q[14:0] > 15'h7C00;
        a_nan  = acc_reg[14:0] > 15'h7C00;
        x_inf  = left_rd_q[14:0] == 15'h7C00;
        y_inf  = right_rd_q[14:0] == 15'h7C00;
        a_inf  = acc_reg[14:0] == 15'h7C00;
        x_zero = left_rd_q[14:0] == 15'd0;
        y_zero = right_rd_q[14:0] == 15'd0;
        a_zero = acc_reg[14:0] == 15'd0;
        c_ps   = left_rd_q[15] ^ right_rd_q[15];
        c_sa   = acc_reg[15];
        c_mx   = {|left_rd_q[14:10], left_rd_q[9:0]};
        c_my   = {|right_rd_q[14:10], right_rd_q[9:0]};
        c_ma   = {|acc_reg[14:10], acc_reg[9:0]};
        c_qx   = (left_rd_q[14:10] == 5'd0) ? 5'd0 : left_rd_q[14:10] - 5'd1;
        c_qy   = (right_rd_q[14:10] == 5'd0) ? 5'd0 : right_rd_q[14:10] - 5'd1;
        c_qa   = (acc_reg[14:10] == 5'd0) ? 5'd0 : acc_reg[14:10] - 5'd1;
        c_sp   = 1'b1;
        c_spv  = fmm_pkg::QNAN16;
        if (x_nan || y_nan || a_nan) begin
            c_spv = fmm_pkg::QNAN16;
        end else if ((x_inf && y_zero) || (y_inf && x_zero)) begin
            c_spv = fmm_pkg::QNAN16;
        end else if (x_inf || y_inf) begin
            if (a_inf && (c_sa != c_ps)) begin
                c_spv = fmm_pkg::QNAN16;
            end else begin
                c_spv = c_ps ? fmm_pkg::NINF16 : fmm_pkg::PINF16;
            end
        end else if (a_inf) begin
            c_spv = acc_reg;
        end else if ((x_zero || y_zero) && a_zero) begin
            c_spv = (c_ps && c_sa) ? fmm_pkg::NZERO16 : 16'd0;
        end else if (x_zero || y_zero) begin
            c_spv = acc_reg;
        end else begin
            c_sp = 1'b0;
        end
    end

    logic        s1_sp, s1_ps, s1_sa;
    logic [15:0] s1_spv;
    logic [21:0] s1_mp;
    logic [5:0]  s1_ep, s1_ea;
    logic [10:0] s1_ma;

    // stage 2..5 registers
    logic [SW-1:0] s2_p, s2_a, s3_sum;
    logic          s3_rs, s4_zero, s5_r, s5_st;
    logic [6:0]    s4_sh;
    logic [10:0]   s5_keep;

    // leading one search
    logic [6:0] lz_n, lz_sh;
    always_comb begin
        lz_n = 7'd0;
        for (int i = 0; i < SW; i++) begin
            if (s3_sum[i]) begin
                lz_n = 7'(i + 1);
            end
        end
        lz_sh = (lz_n > 7'd35) ? lz_n - 7'd11 : 7'd24;
    end

    // guard and sticky extraction
    logic [SW-1:0] sh_val, sh_mask;
    always_comb begin
        sh_val  = s3_sum >> (s4_sh - 7'd1);
        sh_mask = ~({SW{1'b1}} << (s4_sh - 7'd1));
    end

    // final rounding and packing
    logic [11:0] rn_k;
    logic [6:0]  rn_f;
    logic [15:0] rn_res;
    always_comb begin
        rn_k = {1'b0, s5_keep} + {11'd0, s5_r & (s5_st | s5_keep[0])};
        rn_f = s4_sh - 7'd23;
        if (rn_k[11]) begin
            rn_k = rn_k >> 1;
            rn_f = rn_f + 7'd1;
        end
        if (s1_sp) begin
            rn_res = s1_spv;
        end else if (s4_zero) begin
            rn_res = 16'd0;
        end else if (rn_k[10]) begin
            if (rn_f >= 7'd31) begin
                rn_res = {s3_rs, 15'h7C00};
            end else begin
                rn_res = {s3_rs, rn_f[4:0], rn_k[9:0]};
            end
        end else begin
            rn_res = {s3_rs, 5'd0, rn_k[9:0]};
        end
    end

    // output register
    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic [5:0]  out_row_reg, out_col_reg;
    logic        out_load, last_step;
    assign out_load  = (state_reg == fmm_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    assign last_step = (9'(k_reg) + 9'd1) == inner_eff;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_col_reg, out_row_reg, out_value_reg};

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fmm_pkg::ST_IDLE: begin
                if (in_acc && (in_op == fmm_pkg::OP_COMPUTE)
                    && ({3'd0, in_row} < rows_eff) && ({3'd0, in_col} < cols_eff)) begin
                    state_next = fmm_pkg::ST_FETCH;
                end
            end
            fmm_pkg::ST_FETCH: state_next = fmm_pkg::ST_MUL;
            fmm_pkg::ST_MUL:   state_next = fmm_pkg::ST_ALIGN;
            fmm_pkg::ST_ALIGN: state_next = fmm_pkg::ST_ADD;
            fmm_pkg::ST_ADD:   state_next = fmm_pkg::ST_LZC;
            fmm_pkg::ST_LZC:   state_next = fmm_pkg::ST_SHIFT;
            fmm_pkg::ST_SHIFT: state_next = fmm_pkg::ST_ROUND;
            fmm_pkg::ST_ROUND: begin
                state_next = last_step ? fmm_pkg::ST_DONE : fmm_pkg::ST_FETCH;
            end
            fmm_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = fmm_pkg::ST_IDLE;
                end
            end
            default: state_next = fmm_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fmm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == fmm_pkg::ST_IDLE) begin
            row_reg <= in_row;
            col_reg <= in_col;
            k_reg   <= '0;
            acc_reg <= 16'd0;
        end
        if (state_reg == fmm_pkg::ST_MUL) begin
            s1_sp  <= c_sp;
            s1_spv <= c_spv;
            s1_ps  <= c_ps;
            s1_sa  <= c_sa;
            s1_mp  <= c_mx * c_my;
            s1_ep  <= {1'b0, c_qx} + {1'b0, c_qy};
            s1_ma  <= c_ma;
            s1_ea  <= {1'b0, c_qa} + 6'd24;
        end
        if (state_reg == fmm_pkg::ST_ALIGN) begin
            s2_p <= SW'(s1_mp) << s1_ep;
            s2_a <= SW'(s1_ma) << s1_ea;
        end
        if (state_reg == fmm_pkg::ST_ADD) begin
            if (s1_ps == s1_sa) begin
                s3_sum <= s2_p + s2_a;
                s3_rs  <= s1_ps;
            end else if (s2_p >= s2_a) begin
                s3_sum <= s2_p - s2_a;
                s3_rs  <= s1_ps;
            end else begin
                s3_sum <= s2_a - s2_p;
                s3_rs  <= s1_sa;
            end
        end
        if (state_reg == fmm_pkg::ST_LZC) begin
            s4_sh   <= lz_sh;
            s4_zero <= (lz_n == 7'd0);
        end
        if (state_reg == fmm_pkg::ST_SHIFT) begin
            s5_keep <= sh_val[11:1];
            s5_r    <= sh_val[0];
            s5_st   <= |(s3_sum & sh_mask);
        end
        if (state_reg == fmm_pkg::ST_ROUND) begin
            acc_reg <= rn_res;
            k_reg   <= k_reg + KW'(1);
        end
        if (out_load) begin
            out_value_reg <= acc_reg;
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
        end
    end

endmodule

### hdl/fmm_checker.sv
// port-level checker of the fp16 matrix multiply core, bound to the top level
// depends on fmm_pkg and fp16_matrix_multiply_core_defines.svh
`include "fp16_matrix_multiply_core_defines.svh"

module fmm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);

    // stalled result item holds
    `FMM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item dropped or changed under stall")

    // no result right out of reset
    `FMM_ASSERT_RST(a_reset_quiet, !aresetn, !m_tvalid, "result item valid after reset")

    // a new result only follows a busy cycle of the input side
    `FMM_ASSERT_IMP(a_rise_busy, $rose(m_tvalid), !$past(s_tready), "result item appeared without compute")

    // unused result bits stay zero
    `FMM_ASSERT_IMP(a_out_pad, m_tvalid, m_tdata[31:fmm_pkg::M_USED_W] == '0, "result padding not zero")

    // config port never waits
    `FMM_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")

endmodule

bind fp16_matrix_multiply_core fmm_checker u_fmm_checker (.*);
